[hdl/aabbxf_pkg.sv]
// ----------------------------------------------------------------------------
// aabbxf_pkg
// Shared types, widths, register codes and the saturation helper for the
// bounding box transform pipeline.
// ----------------------------------------------------------------------------
package aabbxf_pkg;

	localparam int DATA_W     = 32;                // Q16.16 coordinate
	localparam int COEF_W     = 20;                // Q4.16 coefficient
	localparam int FRAC_W     = 16;
	localparam int NUM_COEF   = 3;
	localparam int CFG_DATA_W = COEF_W * NUM_COEF; // one packed row
	localparam int CFG_IDX_W  = 3;

	localparam int PC_W  = COEF_W + DATA_W;          // coef * center
	localparam int PE_W  = COEF_W + 1 + DATA_W + 1;  // |coef| * extent
	localparam int SUM_W = PE_W;
	localparam int TC_W  = SUM_W - FRAC_W + 1;       // shifted sum plus translation
	localparam int TE_W  = SUM_W - FRAC_W;
	localparam int RES_W = TC_W + 1;                 // center +/- extent

	localparam logic [CFG_DATA_W-1:0] LIN_ROW_X_RST = CFG_DATA_W'(64'd1 << FRAC_W);
	localparam logic [CFG_DATA_W-1:0] LIN_ROW_Y_RST = CFG_DATA_W'(64'd1 << (FRAC_W + COEF_W));
	localparam logic [CFG_DATA_W-1:0] LIN_ROW_Z_RST =
		CFG_DATA_W'(64'd1 << (FRAC_W + 2 * COEF_W));

	localparam logic signed [RES_W-1:0] SAT_HI =
		{{(RES_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [RES_W-1:0] SAT_LO =
		{{(RES_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	typedef logic signed [DATA_W-1:0] coord_t;
	typedef logic signed [DATA_W:0]   ext_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIN_ROW_X = 3'd0,
		REG_LIN_ROW_Y = 3'd1,
		REG_LIN_ROW_Z = 3'd2,
		REG_TRANS_X   = 3'd3,
		REG_TRANS_Y   = 3'd4,
		REG_TRANS_Z   = 3'd5
	} cfg_reg_t;

	// load enables for the stages held inside each row unit
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	function automatic coord_t sat_coord(input logic signed [RES_W-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[DATA_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/aabb_affine_transform.sv]
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Transforms an axis-aligned box through a 3x4 affine matrix by the
// center/extents method, Q16.16 in and out.
// ----------------------------------------------------------------------------
// A box enters on every cycle that in_ready is high; when the output side
// keeps up, one box per clock passes through a five-stage pipeline
// (center/extents, products, row sums, shift and translate, combine and
// saturate). Each stage stalls only when it is full and the
// stage after it cannot take its item, so bubbles are squeezed out under
// backpressure and the output register holds a finished box while new boxes
// keep entering. Configuration writes are always taken (cfg_ready is tied
// high) and must only be made while the pipeline is empty; after reset the
// linear part is the identity and the translation is zero. Out-of-range
// register indexes are ignored. An inverted box (min above max) is passed
// through with a negative extent; only the final corners saturate.
// ----------------------------------------------------------------------------
module aabb_affine_transform (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [aabbxf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [aabbxf_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  aabbxf_pkg::coord_t                     min_x,
	input  aabbxf_pkg::coord_t                     min_y,
	input  aabbxf_pkg::coord_t                     min_z,
	input  aabbxf_pkg::coord_t                     max_x,
	input  aabbxf_pkg::coord_t                     max_y,
	input  aabbxf_pkg::coord_t                     max_z,

	output logic                                   out_valid,
	input  logic                                   out_ready,
	output aabbxf_pkg::coord_t                     out_min_x,
	output aabbxf_pkg::coord_t                     out_min_y,
	output aabbxf_pkg::coord_t                     out_min_z,
	output aabbxf_pkg::coord_t                     out_max_x,
	output aabbxf_pkg::coord_t                     out_max_y,
	output aabbxf_pkg::coord_t                     out_max_z
);
	import aabbxf_pkg::*;

	logic [CFG_DATA_W-1:0] lin_row_q [NUM_COEF];
	coord_t                trans_q   [NUM_COEF];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic en_s1;
	pipe_en_t en;

	coord_t mn     [NUM_COEF];
	coord_t mx     [NUM_COEF];
	ext_t   sum_in [NUM_COEF];
	coord_t ctr    [NUM_COEF];
	ext_t   ext    [NUM_COEF];
	coord_t c_s1   [NUM_COEF];
	ext_t   e_s1   [NUM_COEF];
	coord_t omin_s5 [NUM_COEF];
	coord_t omax_s5 [NUM_COEF];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_row_q[0] <= LIN_ROW_X_RST;
			lin_row_q[1] <= LIN_ROW_Y_RST;
			lin_row_q[2] <= LIN_ROW_Z_RST;
			trans_q[0]   <= '0;
			trans_q[1]   <= '0;
			trans_q[2]   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIN_ROW_X: lin_row_q[0] <= cfg_data;
				REG_LIN_ROW_Y: lin_row_q[1] <= cfg_data;
				REG_LIN_ROW_Z: lin_row_q[2] <= cfg_data;
				REG_TRANS_X:   trans_q[0]   <= cfg_data[DATA_W-1:0];
				REG_TRANS_Y:   trans_q[1]   <= cfg_data[DATA_W-1:0];
				REG_TRANS_Z:   trans_q[2]   <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// stall control: a stage loads when it is empty or its item moves on
	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign en_s1 = rdy_s1 && in_valid;
	assign en.s2 = rdy_s2 && v_s1;
	assign en.s3 = rdy_s3 && v_s2;
	assign en.s4 = rdy_s4 && v_s3;
	assign en.s5 = rdy_s5 && v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage 1: center and extents
	assign mn[0] = min_x;
	assign mn[1] = min_y;
	assign mn[2] = min_z;
	assign mx[0] = max_x;
	assign mx[1] = max_y;
	assign mx[2] = max_z;

	always_comb begin
		for (int i = 0; i < NUM_COEF; i++) begin
			sum_in[i] = (DATA_W + 1)'(mn[i]) + (DATA_W + 1)'(mx[i]);
			// drop the low bit of the full sum: floor halving
			ctr[i]    = sum_in[i][DATA_W:1];
			ext[i]    = (DATA_W + 1)'(mx[i]) - (DATA_W + 1)'(ctr[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				c_s1[i] <= ctr[i];
				e_s1[i] <= ext[i];
			end
		end
	end

	// stages 2 to 5, one unit per output axis
	for (genvar g = 0; g < NUM_COEF; g++) begin : g_row
		aabbxf_row u_row (
			.clk        (clk),
			.en         (en),
			.lin_row    (lin_row_q[g]),
			.trans      (trans_q[g]),
			.c_s1       (c_s1),
			.e_s1       (e_s1),
			.out_min_s5 (omin_s5[g]),
			.out_max_s5 (omax_s5[g])
		);
	end

	assign out_valid = v_s5;
	assign out_min_x = omin_s5[0];
	assign out_min_y = omin_s5[1];
	assign out_min_z = omin_s5[2];
	assign out_max_x = omax_s5[0];
	assign out_max_y = omax_s5[1];
	assign out_max_z = omax_s5[2];

	// items in flight change only by transactions at the two ends
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones({v_s1, v_s2, v_s3, v_s4, v_s5}) ==
			$past($countones({v_s1, v_s2, v_s3, v_s4, v_s5}))
			+ $past(in_valid && in_ready && arst_n)
			- $past(out_valid && out_ready && arst_n)))
		else $error("pipeline occupancy does not match transactions");

	// a full pipeline with a stalled output must push back on the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline is full and stalled");

endmodule

[hdl/aabbxf_row.sv]
// ----------------------------------------------------------------------------
// aabbxf_row
// One output axis: center row product and absolute extent row product,
// row sums, floor shift plus translation, then saturated min/max corner.
// ----------------------------------------------------------------------------
module aabbxf_row (
	input  logic                                 clk,
	input  aabbxf_pkg::pipe_en_t                 en,
	input  logic [aabbxf_pkg::CFG_DATA_W-1:0]    lin_row,
	input  aabbxf_pkg::coord_t                   trans,
	input  aabbxf_pkg::coord_t                   c_s1 [aabbxf_pkg::NUM_COEF],
	input  aabbxf_pkg::ext_t                     e_s1 [aabbxf_pkg::NUM_COEF],
	output aabbxf_pkg::coord_t                   out_min_s5,
	output aabbxf_pkg::coord_t                   out_max_s5
);
	import aabbxf_pkg::*;

	logic signed [COEF_W-1:0] coef     [NUM_COEF];
	logic signed [COEF_W:0]   coef_ext [NUM_COEF];
	logic signed [COEF_W:0]   coef_abs [NUM_COEF];

	logic signed [PC_W-1:0]  pc_s2 [NUM_COEF];
	logic signed [PE_W-1:0]  pe_s2 [NUM_COEF];
	logic signed [SUM_W-1:0] sc_s3;
	logic signed [SUM_W-1:0] se_s3;
	logic signed [TC_W-1:0]  tc_s4;
	logic signed [TE_W-1:0]  te_s4;

	always_comb begin
		for (int j = 0; j < NUM_COEF; j++) begin
			coef[j]     = signed'(lin_row[j*COEF_W +: COEF_W]);
			coef_ext[j] = (COEF_W + 1)'(coef[j]);
			// -8.0 becomes +8.0 in the extra bit
			coef_abs[j] = coef_ext[j][COEF_W] ? -coef_ext[j] : coef_ext[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < NUM_COEF; j++) begin
				pc_s2[j] <= PC_W'(coef[j]) * PC_W'(c_s1[j]);
				pe_s2[j] <= PE_W'(coef_abs[j]) * PE_W'(e_s1[j]);
			end
		end
		if (en.s3) begin
			sc_s3 <= SUM_W'(pc_s2[0]) + SUM_W'(pc_s2[1]) + SUM_W'(pc_s2[2]);
			se_s3 <= pe_s2[0] + pe_s2[1] + pe_s2[2];
		end
		if (en.s4) begin
			// arithmetic shift gives floor rounding
			tc_s4 <= TC_W'(sc_s3 >>> FRAC_W) + TC_W'(trans);
			te_s4 <= TE_W'(se_s3 >>> FRAC_W);
		end
		if (en.s5) begin
			out_min_s5 <= sat_coord(RES_W'(tc_s4) - RES_W'(te_s4));
			out_max_s5 <= sat_coord(RES_W'(tc_s4) + RES_W'(te_s4));
		end
	end

endmodule
